[rtl/inplace_box_blur_3x3_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the in-place 3x3 box filter
// Clocked implication and invariant checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef INPLACE_BOX_BLUR_3X3_MACROS_SVH
`define INPLACE_BOX_BLUR_3X3_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define IBB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Invariant that holds at every clock edge out of reset.
`define IBB_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

`endif

[rtl/ibblur_pkg.sv]
// ----------------------------------------------------------------------------
// ibblur_pkg
// Shared types and constants of the in-place 3x3 box filter.
// ----------------------------------------------------------------------------
package ibblur_pkg;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field and register widths
    localparam int CFG_W = 11;
    localparam int PIX_W = 8;

    // Register reset values and lower clamp bound
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MIN_DIM      = 3;

    // Window sum (9 x 255 fits in 12 bits) and divide-by-9 reciprocal:
    // 3641 / 2^15 = (1/9) * (32769/32768), exact floor for sums below 2^12.
    localparam int SUM_W      = 12;
    localparam int DIV9_MUL   = 3641;
    localparam int DIV9_SHIFT = 15;

    // Configuration register indexes
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // Input transaction kinds
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    // One result entry
    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pix;
    } result_t;

endpackage

[rtl/inplace_box_blur_3x3.sv]
// The result for a pixel is computed once the pixel w+1 positions later
// (or a drain) is accepted; the compute stage forms it in the cycle after
// that accept and writes it into the output queue, where it can be taken.
// Throughput: one transaction per cycle while the output queue has room, set
// by the window read of the two line memories and the 3-entry output queue.
// Reset: counters, pointers and the output queue clear, width/height return
// to 640x480; the line memories are not cleared.
// ----------------------------------------------------------------------------
// inplace_box_blur_3x3
// Streaming in-place 3x3 box filter. Original pixels go to an input line
// memory, emitted results to a result line memory; the 3x3 window is
// rebuilt each cycle from two input reads, one result read and shift taps.
// ----------------------------------------------------------------------------
`include "inplace_box_blur_3x3_macros.svh"

module inplace_box_blur_3x3 #(
    parameter int MAX_WIDTH  = ibblur_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ibblur_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [ibblur_pkg::CFG_W-1:0]  cfg_wr_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ibblur_pkg::PIX_W-1:0]  s_tdata,   // [7:0] pixel_in
    input  logic                          s_tuser,   // [0] cmd
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ibblur_pkg::PIX_W-1:0]  m_tdata,   // [7:0] pixel_out
    output logic                          m_tlast    // frame_end
);
    import ibblur_pkg::*;

    // Line memory depth covers w+2 consecutive entries; power of two wraps
    localparam int AW         = $clog2(MAX_WIDTH + 2);
    localparam int DEPTH      = 2 ** AW;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int HW         = $clog2(MAX_HEIGHT + 2);
    localparam int FIFO_DEPTH = 3;
    localparam int FPW        = 2;

    function automatic logic [AW-1:0] clamp_width(input logic [CFG_W-1:0] v);
        if (int'(v) < MIN_DIM) return AW'(MIN_DIM);
        else if (int'(v) > MAX_WIDTH) return AW'(MAX_WIDTH);
        else return AW'(v);
    endfunction

    function automatic logic [HW-1:0] clamp_height(input logic [CFG_W-1:0] v);
        if (int'(v) < MIN_DIM) return HW'(MIN_DIM);
        else if (int'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
        else return HW'(v);
    endfunction

    // Frame geometry and stream bookkeeping
    logic [AW-1:0]    w_reg;
    logic [HW-1:0]    h_reg;
    logic [AW-1:0]    wr_ptr_reg;   // next input slot
    logic [AW-1:0]    out_ptr_reg;  // slot of the next result (wr_ptr - pending)
    logic [AW-1:0]    pend_reg;     // pixels received, not yet emitted
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [CW-1:0]    col_next;
    logic [RW-1:0]    row_next;

    // Compute stage
    logic             s1_valid_reg;
    logic             s1_interior_reg;
    logic             s1_last_reg;
    logic [AW-1:0]    s1_addr_reg;

    // Line memories and their registered read data
    logic [PIX_W-1:0] in_mem  [DEPTH];
    logic [PIX_W-1:0] res_mem [DEPTH];
    logic [PIX_W-1:0] in_rd_a_reg;  // center, original
    logic [PIX_W-1:0] in_rd_b_reg;  // right neighbor, original
    logic [PIX_W-1:0] res_rd_reg;   // upper-right, filtered

    // Window taps
    logic [PIX_W-1:0] low0_reg, low1_reg, low2_reg;  // lower row, originals
    logic [PIX_W-1:0] up1_reg, up2_reg;              // upper middle/left
    logic [PIX_W-1:0] left_reg;                      // last emitted result

    // Output queue
    result_t          fifo_reg [FIFO_DEPTH];
    logic [FPW-1:0]   fifo_wr_reg;
    logic [FPW-1:0]   fifo_rd_reg;
    logic [FPW-1:0]   fifo_cnt_reg;

    logic             s_accept;
    logic             is_drain;
    logic             pend_full;
    logic             emit;
    logic             col_at_end;
    logic             row_at_end;
    logic             interior;
    logic [SUM_W-1:0] win_sum;
    logic [2*SUM_W-1:0] win_prod;
    logic [PIX_W-1:0] res_pix;
    logic             fifo_pop;

    // Handshake: room for the result in flight plus a new one
    assign s_tready = (3'(fifo_cnt_reg) + 3'(s1_valid_reg)) < 3'(FIFO_DEPTH);
    assign s_accept = s_tvalid && s_tready;
    assign is_drain = (cmd_t'(s_tuser) == CMD_DRAIN);
    assign pend_full = (pend_reg == w_reg + AW'(1));
    assign emit = is_drain ? (pend_reg != '0) : pend_full;

    // Output raster position
    assign col_at_end = (AW'(col_reg) == w_reg - AW'(1));
    assign row_at_end = (HW'(row_reg) == h_reg - HW'(1));
    assign interior = (col_reg != '0) && ((AW'(col_reg) + AW'(2)) <= w_reg) &&
                      (row_reg != '0) && ((HW'(row_reg) + HW'(2)) <= h_reg);

    always_comb begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (col_at_end) begin
            col_next = '0;
            row_next = row_at_end ? '0 : row_reg + RW'(1);
        end
    end

    // Control: geometry, pointers, position, compute stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg        <= clamp_width(CFG_W'(WIDTH_RESET));
            h_reg        <= clamp_height(CFG_W'(HEIGHT_RESET));
            wr_ptr_reg   <= '0;
            out_ptr_reg  <= '0;
            pend_reg     <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept && emit;
            if (cfg_wr_en) begin
                // any register write restarts the frame
                unique case (cfg_index_t'(cfg_addr))
                    REG_IMAGE_WIDTH:  w_reg <= clamp_width(cfg_wr_data);
                    REG_IMAGE_HEIGHT: h_reg <= clamp_height(cfg_wr_data);
                endcase
                pend_reg    <= '0;
                out_ptr_reg <= wr_ptr_reg;
                col_reg     <= '0;
                row_reg     <= '0;
            end else if (s_accept) begin
                if (!is_drain) begin
                    wr_ptr_reg <= wr_ptr_reg + AW'(1);
                end
                if (emit) begin
                    out_ptr_reg <= out_ptr_reg + AW'(1);
                    col_reg     <= col_next;
                    row_reg     <= row_next;
                    if (is_drain) begin
                        pend_reg <= pend_reg - AW'(1);
                    end
                end else if (!is_drain) begin
                    pend_reg <= pend_reg + AW'(1);
                end
            end
        end
    end

    // Compute stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_interior_reg <= !is_drain && interior;
            s1_last_reg     <= col_at_end && row_at_end;
            s1_addr_reg     <= out_ptr_reg;
        end
    end

    // Input line memory: originals written on accept; reads see only slots
    // written in earlier cycles, so no bypass is needed
    always_ff @(posedge aclk) begin
        if (s_accept && !is_drain) begin
            in_mem[wr_ptr_reg] <= s_tdata;
        end
        in_rd_a_reg <= in_mem[out_ptr_reg];
        in_rd_b_reg <= in_mem[out_ptr_reg + AW'(1)];
    end

    // Result line memory: the upper-right tap is at least two results back
    // (w >= 3), so its write has landed before the read
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            res_mem[s1_addr_reg] <= res_pix;
        end
        res_rd_reg <= res_mem[out_ptr_reg - w_reg + AW'(1)];
    end

    // Lower-row taps follow the pixel stream
    always_ff @(posedge aclk) begin
        if (s_accept && !is_drain) begin
            low0_reg <= s_tdata;
            low1_reg <= low0_reg;
            low2_reg <= low1_reg;
        end
    end

    // Window sum and floor divide by 9
    assign win_sum = SUM_W'(low0_reg) + SUM_W'(low1_reg) + SUM_W'(low2_reg) +
                     SUM_W'(in_rd_a_reg) + SUM_W'(in_rd_b_reg) + SUM_W'(left_reg) +
                     SUM_W'(up1_reg) + SUM_W'(up2_reg) + SUM_W'(res_rd_reg);
    assign win_prod = (2*SUM_W)'(win_sum) * (2*SUM_W)'(DIV9_MUL);
    assign res_pix = s1_interior_reg ? win_prod[DIV9_SHIFT +: PIX_W] : in_rd_a_reg;

    // Upper-row and left taps follow the result stream
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            left_reg <= res_pix;
            up1_reg  <= res_rd_reg;
            up2_reg  <= up1_reg;
        end
    end

    // Output queue
    assign fifo_pop = m_tvalid && m_tready;
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = fifo_reg[fifo_rd_reg].pix;
    assign m_tlast  = fifo_reg[fifo_rd_reg].last;

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            fifo_reg[fifo_wr_reg] <= '{last: s1_last_reg, pix: res_pix};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wr_reg  <= '0;
            fifo_rd_reg  <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (s1_valid_reg) begin
                fifo_wr_reg <= (fifo_wr_reg == FPW'(FIFO_DEPTH - 1)) ? '0 :
                               fifo_wr_reg + FPW'(1);
            end
            if (fifo_pop) begin
                fifo_rd_reg <= (fifo_rd_reg == FPW'(FIFO_DEPTH - 1)) ? '0 :
                               fifo_rd_reg + FPW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + FPW'(s1_valid_reg) - FPW'(fifo_pop);
        end
    end

    // Assertions
    `IBB_ASSERT_IMP(a_fifo_no_overflow, aclk, aresetn, s1_valid_reg && !fifo_pop, fifo_cnt_reg < FPW'(FIFO_DEPTH), "output queue overflow")
    `IBB_ASSERT_ALWAYS(a_ptr_gap, aclk, aresetn, (wr_ptr_reg - out_ptr_reg) == pend_reg, "pointer gap differs from pending count")
    `IBB_ASSERT_ALWAYS(a_pend_bound, aclk, aresetn, pend_reg <= w_reg + AW'(1), "pending count beyond one row plus one")

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the in-place 3x3 box filter
// Streams frames of many sizes, including clamped and maximum sizes, with
// premature and empty drains, back-to-back frames and frames cut short by a
// register write. A scoreboard model computes each expected result, and
// every result transaction is checked against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import ibblur_pkg::*;

    localparam int MAX_W       = DEF_MAX_WIDTH;
    localparam int MAX_H       = DEF_MAX_HEIGHT;
    localparam int LINE_DEPTH  = 2 * MAX_W + 2;
    localparam int SETTLE_CYC  = 8;       // block latency margin before a write
    localparam int STALL_LIMIT = 2000;    // cycles without any transaction
    localparam int RAND_ITEMS  = 430;

    // pattern kinds for pixel content
    localparam int PAT_RANDOM  = 0;
    localparam int PAT_WHITE   = 1;
    localparam int PAT_BLACK   = 2;
    localparam int PAT_EXTREME = 3;
    localparam int PAT_DIM     = 4;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic                 cfg_addr;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata;    // [7:0] pixel_in
    logic                 s_tuser;    // [0] cmd
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PIX_W-1:0]     m_tdata;    // [7:0] pixel_out
    logic                 m_tlast;    // frame_end

    // filter model state
    logic [PIX_W-1:0]     line_mem [LINE_DEPTH];
    int unsigned          wr_ptr;
    int unsigned          out_col;
    int unsigned          out_row;
    int unsigned          pend_cnt;
    logic [CFG_W-1:0]     img_width_q;
    logic [CFG_W-1:0]     img_height_q;

    result_t              blur_expect_q[$];
    int unsigned          items_sent;
    int unsigned          err_count;
    int unsigned          idle_cycles;
    bit                   quiet_mode;

    inplace_box_blur_3x3 i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned hi);
        int unsigned d;
        d = 32'(v);
        if (d < MIN_DIM) return MIN_DIM;
        if (d > hi) return hi;
        return d;
    endfunction

    function automatic int unsigned ring_back(input int unsigned a, input int unsigned off);
        return (a + LINE_DEPTH - (off % LINE_DEPTH)) % LINE_DEPTH;
    endfunction

    function automatic int unsigned ring_fwd(input int unsigned a, input int unsigned off);
        return (a + off) % LINE_DEPTH;
    endfunction

    function automatic void frame_restart();
        out_col  = 0;
        out_row  = 0;
        pend_cnt = 0;
    endfunction

    // Advance the model by one accepted input; returns 1 when a result is due.
    function automatic bit blur_predict(input cmd_t cmd, input logic [PIX_W-1:0] pix,
                                        output result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned qa;
        int unsigned sum;
        logic [PIX_W-1:0] val;
        w   = clamp_dim(img_width_q, MAX_W);
        h   = clamp_dim(img_height_q, MAX_H);
        res = '0;
        if (cmd == CMD_DRAIN) begin
            if (pend_cnt == 0) return 1'b0;
            // drain: stored value of the oldest pending pixel, unfiltered
            val = line_mem[ring_back(wr_ptr, pend_cnt)];
            pend_cnt--;
        end else if (pend_cnt >= w + 1) begin
            qa = ring_back(wr_ptr, w + 1);
            if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w) begin
                // upper row and left tap are already filtered values
                sum = 32'(pix);
                sum += 32'(line_mem[ring_back(qa, w + 1)]);
                sum += 32'(line_mem[ring_back(qa, w)]);
                sum += 32'(line_mem[ring_back(qa, w - 1)]);
                sum += 32'(line_mem[ring_back(qa, 1)]);
                sum += 32'(line_mem[qa]);
                sum += 32'(line_mem[ring_fwd(qa, 1)]);
                sum += 32'(line_mem[ring_fwd(qa, w - 1)]);
                sum += 32'(line_mem[ring_fwd(qa, w)]);
                val = PIX_W'(sum / 9);
            end else begin
                val = line_mem[qa];
            end
            line_mem[wr_ptr] = pix;
            line_mem[qa]     = val;
            wr_ptr           = ring_fwd(wr_ptr, 1);
        end else begin
            line_mem[wr_ptr] = pix;
            wr_ptr           = ring_fwd(wr_ptr, 1);
            pend_cnt++;
            return 1'b0;
        end
        res.pix  = val;
        res.last = (out_row == h - 1 && out_col == w - 1);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) out_row = 0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Send one input transaction and update the model when it is accepted.
    task automatic push_item(input cmd_t cmd, input logic [PIX_W-1:0] pix);
        int unsigned gap;
        result_t     res;
        gap = quiet_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_PIXEL || pend_cnt != 0) items_sent++;
        if (blur_predict(cmd, pix, res)) blur_expect_q.push_back(res);
    endtask

    // Register write, only once every expected result is out.
    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        while (blur_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) img_width_q = val;
        else                        img_height_q = val;
        frame_restart();
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        if ($urandom_range(0, 1)) begin
            cfg_write(REG_IMAGE_WIDTH, w_raw);
            cfg_write(REG_IMAGE_HEIGHT, h_raw);
        end else begin
            cfg_write(REG_IMAGE_HEIGHT, h_raw);
            cfg_write(REG_IMAGE_WIDTH, w_raw);
        end
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input int pattern);
        case (pattern)
            PAT_WHITE:   return 8'hFF;
            PAT_BLACK:   return 8'h00;
            PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PAT_DIM:     return PIX_W'($urandom_range(0, 15));
            default:     return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Stream pixels; a noisy stream slips in premature drains.
    task automatic stream_pixels(input int unsigned n, input int pattern, input bit noisy);
        for (int unsigned i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 24) == 0)
                push_item(CMD_DRAIN, PIX_W'($urandom_range(0, 255)));
            push_item(CMD_PIXEL, pick_pixel(pattern));
        end
    endtask

    task automatic flush_pending(input bit extra);
        while (pend_cnt != 0) push_item(CMD_DRAIN, PIX_W'($urandom_range(0, 255)));
        if (extra) push_item(CMD_DRAIN, PIX_W'($urandom_range(0, 255)));
    endtask

    function automatic int unsigned frame_pixels();
        return clamp_dim(img_width_q, MAX_W) * clamp_dim(img_height_q, MAX_H);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset size 640x480: only row 0 can drain, passed through.
    task automatic test_power_on_defaults();
        stream_pixels(12, PAT_RANDOM, 1'b0);
        flush_pending(1'b1);
    endtask

    // Smallest frame: one interior pixel, extremes, back-to-back frames.
    task automatic test_min_frame();
        set_frame(11'd3, 11'd3);
        stream_pixels(9, PAT_WHITE, 1'b0);
        stream_pixels(9, PAT_EXTREME, 1'b0);
        flush_pending(1'b1);
    endtask

    // Random sizes, contents, frame counts, cut-short frames and idling.
    task automatic test_random_frames();
        int unsigned start_items;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned n_frames;
        start_items = items_sent;
        while (items_sent < start_items + RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w_raw = $urandom_range(0, 3);
                1:       w_raw = $urandom_range(13, 40);
                default: w_raw = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 9))
                0:       h_raw = $urandom_range(0, 3);
                1:       h_raw = $urandom_range(8, 12);
                default: h_raw = $urandom_range(3, 6);
            endcase
            set_frame(CFG_W'(w_raw), CFG_W'(h_raw));
            quiet_mode = ($urandom_range(0, 3) == 0);
            n_frames   = $urandom_range(1, 3);
            for (int unsigned f = 0;
                 f < n_frames && items_sent < start_items + RAND_ITEMS; f++)
                stream_pixels(frame_pixels(), $urandom_range(PAT_RANDOM, PAT_DIM),
                              $urandom_range(0, 2) == 0);
            // broken frame left pending: the next register write drops it
            if ($urandom_range(0, 4) == 0)
                stream_pixels($urandom_range(1, frame_pixels() - 1), PAT_RANDOM, 1'b0);
            else
                flush_pending(1'($urandom_range(0, 1)));
        end
        quiet_mode = 1'b0;
    endtask

    // Register maxima: width clamped to MAX_W on a partial frame that the
    // next register write drops, then height clamped to MAX_H so that the
    // first rows of a narrow frame stay interior.
    task automatic test_max_dims();
        set_frame(11'h7FF, 11'd3);
        stream_pixels(MAX_W + 6, PAT_RANDOM, 1'b0);
        set_frame(11'd0, 11'h7FF);
        stream_pixels(12 * MIN_DIM, PAT_RANDOM, 1'b0);
        flush_pending(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (blur_expect_q.size() == 0) begin
                report_mismatch($sformatf("result with none expected: pix=%0d last=%0b",
                                          m_tdata, m_tlast));
            end else begin
                want = blur_expect_q.pop_front();
                if (m_tdata !== want.pix)
                    report_mismatch($sformatf("pixel_out got %0d want %0d", m_tdata, want.pix));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("frame_end got %0b want %0b", m_tlast, want.last));
            end
        end
    end

    // Result side backpressure, drawn per transaction.
    initial begin : result_ready
        int unsigned stall;
        forever begin
            stall = quiet_mode ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
        end
    end

    // Watchdog on cycles with no transaction of any kind.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= REG_IMAGE_WIDTH;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_PIXEL;
        items_sent   = 0;
        err_count    = 0;
        idle_cycles  = 0;
        quiet_mode   = 1'b0;
        img_width_q  = CFG_W'(WIDTH_RESET);
        img_height_q = CFG_W'(HEIGHT_RESET);
        wr_ptr       = 0;
        foreach (line_mem[i]) line_mem[i] = '0;
        frame_restart();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_power_on_defaults();
        test_min_frame();
        test_random_frames();
        test_max_dims();

        s_tvalid <= 1'b0;
        while (blur_expect_q.size() != 0) @(posedge aclk);
        repeat (4 * SETTLE_CYC) @(posedge aclk);
        if (blur_expect_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", blur_expect_q.size()));

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
